/* rtl/cts_pkg.sv */
// Shared types, constants and frame helpers of the CANopen trajectory sequencer.
package cts_pkg;

   // Payload widths of the request and response items.
   localparam int unsigned CmdWidth      = 2;
   localparam int unsigned LoadAddrWidth = 10;
   localparam int unsigned PosWidth      = 32;
   localparam int unsigned FrameIdWidth  = 11;
   localparam int unsigned FrameLenWidth = 4;
   localparam int unsigned FrameDataWidth = 64;
   localparam int unsigned ToleranceWidth = 16;
   localparam int unsigned CountWidth    = 11;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned ReqDataWidth  = 120;
   localparam int unsigned RspDataWidth  = 80;
   localparam int unsigned StepWidth     = 4;

   typedef enum logic [CmdWidth-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_POLL  = 2'd2,
      CMD_FRAME = 2'd3
   } command_type;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_COMMAND_ID  = 3'd0,
      REG_RESPONSE_ID = 3'd1,
      REG_TOLERANCE   = 3'd2,
      REG_ACCEL       = 3'd3,
      REG_DECEL       = 3'd4,
      REG_SPEED       = 3'd5,
      REG_POINT_COUNT = 3'd6
   } reg_index_type;

   // Frames in the order of the start sequence, then the position poll.
   typedef enum logic [StepWidth-1:0] {
      FR_NMT    = 4'd0,
      FR_MODE   = 4'd1,
      FR_CW80   = 4'd2,
      FR_CW06   = 4'd3,
      FR_CW07   = 4'd4,
      FR_ACCEL  = 4'd5,
      FR_DECEL  = 4'd6,
      FR_SPEED  = 4'd7,
      FR_CW0F   = 4'd8,
      FR_TARGET = 4'd9,
      FR_CW1F   = 4'd10,
      FR_POLL   = 4'd11
   } frame_code_type;

   localparam logic [StepWidth-1:0] START_LAST_FULL  = 4'd10;
   localparam logic [StepWidth-1:0] START_LAST_EMPTY = 4'd8;

   // Reset values of the configuration registers.
   localparam logic [FrameIdWidth-1:0]   RST_COMMAND_ID  = 11'd1537;
   localparam logic [FrameIdWidth-1:0]   RST_RESPONSE_ID = 11'd1409;
   localparam logic [ToleranceWidth-1:0] RST_TOLERANCE   = 16'd500;
   localparam logic [PosWidth-1:0]       RST_PROFILE     = 32'd5566;
   localparam logic [CountWidth-1:0]     RST_POINT_COUNT = 11'd0;

   // CANopen SDO command specifiers and object indexes.
   localparam logic [7:0]  CS_WRITE_1 = 8'h2F;
   localparam logic [7:0]  CS_WRITE_2 = 8'h2B;
   localparam logic [7:0]  CS_WRITE_4 = 8'h23;
   localparam logic [7:0]  CS_READ    = 8'h40;
   localparam logic [15:0] OBJ_MODE        = 16'h6060;
   localparam logic [15:0] OBJ_CONTROLWORD = 16'h6040;
   localparam logic [15:0] OBJ_ACCEL       = 16'h6083;
   localparam logic [15:0] OBJ_DECEL       = 16'h6084;
   localparam logic [15:0] OBJ_SPEED       = 16'h6081;
   localparam logic [15:0] OBJ_TARGET      = 16'h607A;
   localparam logic [15:0] OBJ_ACTUAL      = 16'h6064;
   localparam logic [7:0]  ACTUAL_LOW      = 8'h64;
   localparam logic [7:0]  ACTUAL_HIGH     = 8'h60;
   localparam logic [31:0] MODE_PROFILE_POS = 32'h01;
   localparam logic [31:0] CW_SHUTDOWN_80  = 32'h80;
   localparam logic [31:0] CW_SHUTDOWN     = 32'h06;
   localparam logic [31:0] CW_SWITCH_ON    = 32'h07;
   localparam logic [31:0] CW_ENABLE       = 32'h0F;
   localparam logic [31:0] CW_NEW_SETPOINT = 32'h1F;
   localparam logic [FrameIdWidth-1:0]   NMT_ID   = 11'd0;
   localparam logic [FrameDataWidth-1:0] NMT_START = 64'h0101;
   localparam logic [FrameLenWidth-1:0]  FRAME_LEN = 4'd8;

   // SDO payload: specifier in byte 0, object in bytes 1-2, value in bytes 4-7.
   function automatic logic [FrameDataWidth-1:0] sdo_bytes(input logic [7:0] cs,
                                                           input logic [15:0] obj,
                                                           input logic [31:0] value);
      sdo_bytes = {value, 8'h00, obj, cs};
   endfunction

endpackage

/* rtl/canopen_trajectory_sequencer.sv */
// Top level of the CANopen profile-position trajectory sequencer.
//
// Requests arrive on the req_ stream: req_tuser carries the command (load point, start,
// poll tick, received frame) and req_tdata the load slot, load value and received frame.
// Each request causes zero to eleven CAN frames on the rsp_ stream; rsp_tlast marks the
// final frame caused by one request. Configuration is written through csr_we, csr_index
// and csr_wdata; the user must write it only while the block is idle, as the block does not enforce this.
// A request is taken into the job registers while its point table reads are registered;
// its first frame is then loaded into the output register (the arrival compare uses the
// registered table read) and frames follow one per cycle as the receiver takes them.
// The next request is taken at the edge where the last frame of the current one enters
// the output register or where an ignored frame ends its job; a load starts no job.
// The point table is a two-read-port memory read at the request edge. Its contents are
// undefined after reset; configuration registers return to their reset values and the
// point index to zero. While the receiver stalls, the output register holds its frame
// and the sequencer waits.
module canopen_trajectory_sequencer #(
   parameter int unsigned MAX_POINTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // from bit 0: load_address[9:0], load_value[41:10], rx_frame_id[52:42],
   // rx_frame_data[116:53], zero fill[119:117]
   input  logic [cts_pkg::ReqDataWidth-1:0]     req_tdata,
   // from bit 0: command[1:0]
   input  logic [cts_pkg::CmdWidth-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // from bit 0: tx_frame_id[10:0], tx_frame_length[14:11], tx_frame_data[78:15],
   // zero fill[79]
   output logic [cts_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [cts_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [cts_pkg::CsrDataWidth-1:0]     csr_wdata
);

   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

   // Request fields.
   cts_pkg::command_type                    req_cmd;
   logic [cts_pkg::LoadAddrWidth-1:0]       req_load_address;
   logic [cts_pkg::PosWidth-1:0]            req_load_value;
   logic [cts_pkg::FrameIdWidth-1:0]        req_rx_frame_id;
   logic [cts_pkg::FrameDataWidth-1:0]      req_rx_frame_data;
   logic                                    req_accept;

   assign req_cmd           = cts_pkg::command_type'(req_tuser);
   assign req_load_address  = req_tdata[9:0];
   assign req_load_value    = req_tdata[41:10];
   assign req_rx_frame_id   = req_tdata[52:42];
   assign req_rx_frame_data = req_tdata[116:53];
   assign req_accept        = req_tvalid && req_tready;

   // Configuration registers.
   logic [cts_pkg::FrameIdWidth-1:0]   command_id_ff, response_id_ff;
   logic [cts_pkg::ToleranceWidth-1:0] tolerance_ff;
   logic [cts_pkg::PosWidth-1:0]       accel_ff, decel_ff, speed_ff;
   logic [cts_pkg::CountWidth-1:0]     point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_id_ff  <= cts_pkg::RST_COMMAND_ID;
         response_id_ff <= cts_pkg::RST_RESPONSE_ID;
         tolerance_ff   <= cts_pkg::RST_TOLERANCE;
         accel_ff       <= cts_pkg::RST_PROFILE;
         decel_ff       <= cts_pkg::RST_PROFILE;
         speed_ff       <= cts_pkg::RST_PROFILE;
         point_count_ff <= cts_pkg::RST_POINT_COUNT;
      end else if (csr_we) begin
         case (cts_pkg::reg_index_type'(csr_index))
            cts_pkg::REG_COMMAND_ID:  command_id_ff  <= csr_wdata[10:0];
            cts_pkg::REG_RESPONSE_ID: response_id_ff <= csr_wdata[10:0];
            cts_pkg::REG_TOLERANCE:   tolerance_ff   <= csr_wdata[15:0];
            cts_pkg::REG_ACCEL:       accel_ff       <= csr_wdata;
            cts_pkg::REG_DECEL:       decel_ff       <= csr_wdata;
            cts_pkg::REG_SPEED:       speed_ff       <= csr_wdata;
            cts_pkg::REG_POINT_COUNT: point_count_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // A point count above the table depth counts as a full table.
   logic [31:0]      count_wide;
   logic [31:0]      count_clamped;
   logic [CNT_W-1:0] eff_count;

   assign count_wide    = {21'd0, point_count_ff};
   assign count_clamped = (count_wide > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : count_wide;
   assign eff_count     = count_clamped[CNT_W-1:0];

   // Point index and table addressing.
   logic [IDX_W-1:0] point_index_ff, point_index_in;
   logic [IDX_W:0]   index_next_wide;
   logic [IDX_W-1:0] index_next;
   logic [IDX_W-1:0] rd_addr0, rd_addr1;
   logic             load_in_range;

   assign index_next_wide = {1'b0, point_index_ff} + {{IDX_W{1'b0}}, 1'b1};
   assign index_next = (index_next_wide == (IDX_W+1)'(MAX_POINTS)) ? '0
                                                                   : index_next_wide[IDX_W-1:0];
   // A start reads points 0 and 1, every other request the current point and the one after it.
   assign rd_addr0 = (req_cmd == cts_pkg::CMD_START) ? '0 : point_index_ff;
   assign rd_addr1 = (req_cmd == cts_pkg::CMD_START) ? IDX_W'(1) : index_next;
   assign load_in_range = {22'd0, req_load_address} < 32'(MAX_POINTS);

   // Point table: one write port, two registered read ports, all on the request edge.
   logic [cts_pkg::PosWidth-1:0] point_mem [MAX_POINTS];
   logic [cts_pkg::PosWidth-1:0] rd_data0_ff, rd_data1_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (req_cmd == cts_pkg::CMD_LOAD && load_in_range) begin
            point_mem[IDX_W'(req_load_address)] <= req_load_value;
         end
         rd_data0_ff <= point_mem[rd_addr0];
         rd_data1_ff <= point_mem[rd_addr1];
      end
   end

   // Job registers: the request being turned into frames.
   logic                               job_valid_ff, job_valid_in;
   cts_pkg::command_type               job_kind_ff;
   logic [cts_pkg::StepWidth-1:0]      job_step_ff, job_step_in;
   logic [cts_pkg::FrameIdWidth-1:0]   job_rx_id_ff;
   logic [cts_pkg::FrameDataWidth-1:0] job_rx_data_ff;

   // Output register.
   logic                               rsp_valid_ff;
   logic [cts_pkg::FrameIdWidth-1:0]   rsp_id_ff;
   logic [cts_pkg::FrameDataWidth-1:0] rsp_data_ff;
   logic                               rsp_last_ff;
   logic                               out_load;

   assign out_load = !rsp_valid_ff || rsp_tready;

   // Arrival check of a received position response against the current point.
   logic                  fb_match;
   logic signed [32:0]    fb_diff;
   logic [32:0]           fb_abs;
   logic                  fb_go;

   assign fb_match = (job_rx_id_ff == response_id_ff)
                  && (job_rx_data_ff[15:8] == cts_pkg::ACTUAL_LOW)
                  && (job_rx_data_ff[23:16] == cts_pkg::ACTUAL_HIGH)
                  && (eff_count != '0);
   assign fb_diff = $signed({job_rx_data_ff[63], job_rx_data_ff[63:32]})
                  - $signed({rd_data0_ff[31], rd_data0_ff});
   assign fb_abs  = fb_diff[32] ? 33'(-fb_diff) : 33'(fb_diff);
   assign fb_go   = fb_match && (fb_abs <= {17'd0, tolerance_ff})
                 && ((CNT_W'(point_index_ff) + CNT_W'(1)) < eff_count);

   // Frame selection for the current job step.
   cts_pkg::frame_code_type            frame_code;
   logic                               frame_valid;
   logic                               frame_last;
   logic                               frame_move;
   logic                               job_done;
   logic [cts_pkg::PosWidth-1:0]       target_pos;
   logic [cts_pkg::FrameIdWidth-1:0]   frame_id;
   logic [cts_pkg::FrameDataWidth-1:0] frame_data;

   always_comb begin
      frame_code  = cts_pkg::FR_POLL;
      frame_valid = 1'b0;
      frame_last  = 1'b0;
      case (job_kind_ff)
         cts_pkg::CMD_START: begin
            frame_code  = cts_pkg::frame_code_type'(job_step_ff);
            frame_valid = job_valid_ff;
            frame_last  = (eff_count != '0) ? (job_step_ff == cts_pkg::START_LAST_FULL)
                                            : (job_step_ff == cts_pkg::START_LAST_EMPTY);
         end
         cts_pkg::CMD_POLL: begin
            frame_code  = cts_pkg::FR_POLL;
            frame_valid = job_valid_ff;
            frame_last  = 1'b1;
         end
         cts_pkg::CMD_FRAME: begin
            // The index advances with the target frame, so only the first step is checked.
            frame_code  = (job_step_ff == '0) ? cts_pkg::FR_TARGET : cts_pkg::FR_CW1F;
            frame_valid = job_valid_ff && ((job_step_ff != '0) || fb_go);
            frame_last  = (job_step_ff != '0);
         end
         default: ;
      endcase
   end

   assign target_pos = (job_kind_ff == cts_pkg::CMD_START) ? rd_data0_ff : rd_data1_ff;

   always_comb begin
      frame_id = command_id_ff;
      case (frame_code)
         cts_pkg::FR_NMT: begin
            frame_id   = cts_pkg::NMT_ID;
            frame_data = cts_pkg::NMT_START;
         end
         cts_pkg::FR_MODE:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_1, cts_pkg::OBJ_MODE,
                                            cts_pkg::MODE_PROFILE_POS);
         cts_pkg::FR_CW80:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_2, cts_pkg::OBJ_CONTROLWORD,
                                            cts_pkg::CW_SHUTDOWN_80);
         cts_pkg::FR_CW06:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_2, cts_pkg::OBJ_CONTROLWORD,
                                            cts_pkg::CW_SHUTDOWN);
         cts_pkg::FR_CW07:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_2, cts_pkg::OBJ_CONTROLWORD,
                                            cts_pkg::CW_SWITCH_ON);
         cts_pkg::FR_ACCEL:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_4, cts_pkg::OBJ_ACCEL, accel_ff);
         cts_pkg::FR_DECEL:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_4, cts_pkg::OBJ_DECEL, decel_ff);
         cts_pkg::FR_SPEED:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_4, cts_pkg::OBJ_SPEED, speed_ff);
         cts_pkg::FR_CW0F:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_2, cts_pkg::OBJ_CONTROLWORD,
                                            cts_pkg::CW_ENABLE);
         cts_pkg::FR_TARGET:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_4, cts_pkg::OBJ_TARGET,
                                            target_pos);
         cts_pkg::FR_CW1F:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_WRITE_2, cts_pkg::OBJ_CONTROLWORD,
                                            cts_pkg::CW_NEW_SETPOINT);
         cts_pkg::FR_POLL:
            frame_data = cts_pkg::sdo_bytes(cts_pkg::CS_READ, cts_pkg::OBJ_ACTUAL, 32'd0);
         default:
            frame_data = '0;
      endcase
   end

   assign frame_move = frame_valid && out_load;
   // A received frame that fails the arrival check ends its job without a frame.
   assign job_done = job_valid_ff
                  && ((frame_move && frame_last)
                   || (job_kind_ff == cts_pkg::CMD_FRAME && job_step_ff == '0 && !fb_go));
   assign req_tready = !job_valid_ff || job_done;

   always_comb begin
      job_valid_in = job_valid_ff;
      job_step_in  = job_step_ff;
      if (job_done) begin
         job_valid_in = 1'b0;
      end else if (frame_move) begin
         job_step_in = job_step_ff + cts_pkg::StepWidth'(1);
      end
      if (req_accept) begin
         job_valid_in = (req_cmd != cts_pkg::CMD_LOAD);
         job_step_in  = '0;
      end
   end

   always_comb begin
      point_index_in = point_index_ff;
      if (frame_move && job_kind_ff == cts_pkg::CMD_FRAME && job_step_ff == '0) begin
         point_index_in = index_next;
      end
      if (req_accept && req_cmd == cts_pkg::CMD_START) begin
         point_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff   <= 1'b0;
         job_step_ff    <= '0;
         job_kind_ff    <= cts_pkg::CMD_LOAD;
         point_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         job_valid_ff   <= job_valid_in;
         job_step_ff    <= job_step_in;
         point_index_ff <= point_index_in;
         if (req_accept) begin
            job_kind_ff <= req_cmd;
         end
         if (out_load) begin
            rsp_valid_ff <= frame_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         job_rx_id_ff   <= req_rx_frame_id;
         job_rx_data_ff <= req_rx_frame_data;
      end
      if (frame_move) begin
         rsp_id_ff   <= frame_id;
         rsp_data_ff <= frame_data;
         rsp_last_ff <= frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff, cts_pkg::FRAME_LEN, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
